### sv/bavg_pkg.sv
`default_nettype none
package bavg_pkg;

  localparam int MAX_ICON_COLS   = 64;
  localparam int MAX_BLOCK_SIDE  = 64;
  localparam int MAX_SOURCE_SIDE = 4096;

  localparam int ICOL_W  = $clog2(MAX_ICON_COLS);      // icon column index
  localparam int BCI_W   = ICOL_W + 1;                 // saturating column index
  localparam int BCNT_W  = $clog2(MAX_BLOCK_SIDE);     // in-block counters
  localparam int BSIDE_W = BCNT_W + 1;                 // block side register
  localparam int SCNT_W  = $clog2(MAX_SOURCE_SIDE);    // source counters, band index
  localparam int SSIDE_W = SCNT_W + 1;                 // source side register
  localparam int PIX_W   = 8;
  localparam int AVG_W   = 8;
  localparam int SUM_W   = 20;
  localparam int ACC_W   = SUM_W + 1;                  // stored sum plus one pixel
  localparam int AREA_W  = 2 * BCNT_W + 1;
  localparam int NUM_W   = ACC_W + 2;                  // 2*sum + area
  localparam int DEN_W   = AREA_W + 1;                 // 2*area
  localparam int QCNT_W  = $clog2(NUM_W);

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = SSIDE_W;

  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_ROWS = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_COLS = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_ROWS  = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_COLS  = CFG_IDX_W'(3);

  typedef struct packed {
    logic accept;     // take the pixel, step the counters, read the column sum
    logic commit;     // write back the sum or retire the column
    logic div_start;  // launch the average division
    logic out_load;   // move the finished item into the output register
  } bavg_cmd_t;

  typedef struct packed {
    logic in_range;   // current block column has a sum slot
    logic emit;       // latched item closes its block
    logic div_idle;   // divider holds a finished quotient
  } bavg_sts_t;

  function automatic logic [SSIDE_W-1:0] clamp_src(input logic [SSIDE_W-1:0] v);
    logic [SSIDE_W-1:0] r;
    if (v == '0) begin
      r = SSIDE_W'(1);
    end else if (v > SSIDE_W'(MAX_SOURCE_SIDE)) begin
      r = SSIDE_W'(MAX_SOURCE_SIDE);
    end else begin
      r = v;
    end
    return r;
  endfunction

  function automatic logic [BSIDE_W-1:0] clamp_blk(input logic [BSIDE_W-1:0] v);
    logic [BSIDE_W-1:0] r;
    if (v == '0) begin
      r = BSIDE_W'(1);
    end else if (v > BSIDE_W'(MAX_BLOCK_SIDE)) begin
      r = BSIDE_W'(MAX_BLOCK_SIDE);
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

### sv/bavg_div.sv
`default_nettype none
module bavg_div
  import bavg_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [NUM_W-1:0] num,
  input  wire logic [DEN_W-1:0] den,
  output logic                  idle,
  output logic [AVG_W-1:0]      quot
);

  // restoring division, one quotient bit per cycle
  logic              busy_r, busy_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic [DEN_W-1:0]  rem_r, rem_nxt;
  logic [NUM_W-1:0]  q_r, q_nxt;
  logic [DEN_W-1:0]  den_r, den_nxt;
  logic [DEN_W:0]    trial;
  logic [DEN_W:0]    diff;
  logic              ge;

  assign trial = {rem_r, q_r[NUM_W-1]};
  assign diff  = trial - {1'b0, den_r};
  assign ge    = trial >= {1'b0, den_r};

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    q_nxt    = q_r;
    den_nxt  = den_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = QCNT_W'(NUM_W - 1);
      rem_nxt  = '0;
      q_nxt    = num;
      den_nxt  = den;
    end else if (busy_r) begin
      rem_nxt = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      q_nxt   = {q_r[NUM_W-2:0], ge};
      cnt_nxt = cnt_r - QCNT_W'(1);
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    q_r   <= q_nxt;
    den_r <= den_nxt;
  end

  assign idle = !busy_r;
  // saturate at full white
  assign quot = (|q_r[NUM_W-1:AVG_W]) ? '1 : q_r[AVG_W-1:0];

`ifndef ASSERT_OFF
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> busy_r)
    else $error("divider not busy after start");
  a_finish: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r && (cnt_r == '0) && !start |=> !busy_r)
    else $error("divider overran its step count");
  a_stay_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !busy_r && !start |=> !busy_r)
    else $error("divider woke without start");
`endif

endmodule
`default_nettype wire

### sv/bavg_dp.sv
`default_nettype none
module bavg_dp
  import bavg_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire bavg_cmd_t          cmd,
  input  wire logic [PIX_W-1:0]   in_pixel,
  input  wire logic [SSIDE_W-1:0] src_rows,
  input  wire logic [SSIDE_W-1:0] src_cols,
  input  wire logic [BSIDE_W-1:0] blk_rows,
  input  wire logic [BSIDE_W-1:0] blk_cols,
  input  wire logic [AREA_W-1:0]  area,
  output logic                    in_range,
  output logic                    emit,
  output logic [NUM_W-1:0]        num,
  output logic [SCNT_W-1:0]       item_row,
  output logic [ICOL_W-1:0]       item_col,
  output logic                    item_last
);

  logic [SCNT_W-1:0] src_row_cnt_r, src_row_cnt_nxt;
  logic [SCNT_W-1:0] src_col_cnt_r, src_col_cnt_nxt;
  logic [SCNT_W-1:0] band_r, band_nxt;
  logic [BCNT_W-1:0] row_in_band_r, row_in_band_nxt;
  logic [BCNT_W-1:0] col_in_blk_r, col_in_blk_nxt;
  logic [BCI_W-1:0]  bci_r, bci_nxt;

  logic [SSIDE_W-1:0] col_inc, row_inc;
  logic [BSIDE_W-1:0] cib_inc, rib_inc;
  logic               last_col, last_row, h_end, v_end;

  // latched item
  logic [PIX_W-1:0]  px_r;
  logic [ICOL_W-1:0] idx_r;
  logic              emit_r;
  logic              last_r;
  logic [SCNT_W-1:0] row_r;

  logic [SUM_W-1:0]         sums_mem [MAX_ICON_COLS];
  logic [MAX_ICON_COLS-1:0] vld_r;
  logic [SUM_W-1:0]         rd_r;
  logic [ACC_W-1:0]         acc;

  assign col_inc  = SSIDE_W'(src_col_cnt_r) + SSIDE_W'(1);
  assign row_inc  = SSIDE_W'(src_row_cnt_r) + SSIDE_W'(1);
  assign cib_inc  = BSIDE_W'(col_in_blk_r) + BSIDE_W'(1);
  assign rib_inc  = BSIDE_W'(row_in_band_r) + BSIDE_W'(1);
  assign last_col = col_inc >= src_cols;
  assign last_row = row_inc >= src_rows;
  assign h_end    = (cib_inc >= blk_cols) || last_col;
  assign v_end    = (rib_inc >= blk_rows) || last_row;
  assign in_range = bci_r < BCI_W'(MAX_ICON_COLS);

  always_comb begin
    src_row_cnt_nxt = src_row_cnt_r;
    src_col_cnt_nxt = src_col_cnt_r;
    band_nxt        = band_r;
    row_in_band_nxt = row_in_band_r;
    col_in_blk_nxt  = col_in_blk_r;
    bci_nxt         = bci_r;
    if (cmd.accept) begin
      if (last_col) begin
        src_col_cnt_nxt = '0;
        col_in_blk_nxt  = '0;
        bci_nxt         = '0;
        if (last_row) begin
          src_row_cnt_nxt = '0;
          row_in_band_nxt = '0;
          band_nxt        = '0;
        end else begin
          src_row_cnt_nxt = src_row_cnt_r + SCNT_W'(1);
          if (v_end) begin
            row_in_band_nxt = '0;
            band_nxt        = band_r + SCNT_W'(1);
          end else begin
            row_in_band_nxt = row_in_band_r + BCNT_W'(1);
          end
        end
      end else begin
        src_col_cnt_nxt = src_col_cnt_r + SCNT_W'(1);
        if (h_end) begin
          col_in_blk_nxt = '0;
          if (in_range) begin
            bci_nxt = bci_r + BCI_W'(1);
          end
        end else begin
          col_in_blk_nxt = col_in_blk_r + BCNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_row_cnt_r <= '0;
      src_col_cnt_r <= '0;
      band_r        <= '0;
      row_in_band_r <= '0;
      col_in_blk_r  <= '0;
      bci_r         <= '0;
      emit_r        <= 1'b0;
    end else begin
      src_row_cnt_r <= src_row_cnt_nxt;
      src_col_cnt_r <= src_col_cnt_nxt;
      band_r        <= band_nxt;
      row_in_band_r <= row_in_band_nxt;
      col_in_blk_r  <= col_in_blk_nxt;
      bci_r         <= bci_nxt;
      if (cmd.accept) begin
        emit_r <= h_end && v_end;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      px_r   <= in_pixel;
      idx_r  <= bci_r[ICOL_W-1:0];
      last_r <= last_row && last_col;
      row_r  <= band_r;
    end
  end

  // column sum store: read on accept, write back on commit unless the block closes
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      rd_r <= sums_mem[bci_r[ICOL_W-1:0]];
    end
    if (cmd.commit && !emit_r) begin
      sums_mem[idx_r] <= acc[SUM_W-1:0];
    end
  end

  // a cleared column reads as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (cmd.commit) begin
      vld_r[idx_r] <= !emit_r;
    end
  end

  assign acc = ACC_W'(vld_r[idx_r] ? rd_r : '0) + ACC_W'(px_r);
  assign num = NUM_W'({acc, 1'b0}) + NUM_W'(area);

  assign emit      = emit_r;
  assign item_row  = row_r;
  assign item_col  = idx_r;
  assign item_last = last_r;

`ifndef ASSERT_OFF
  a_keep: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit && !emit_r |=> vld_r[$past(idx_r)])
    else $error("column sum not marked live after write back");
  a_retire: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit && emit_r |=> !vld_r[$past(idx_r)])
    else $error("finished column not cleared");
  a_sat: assert property (@(posedge clk) disable iff (!rst_n)
    bci_r <= BCI_W'(MAX_ICON_COLS))
    else $error("block column index past saturation");
`endif

endmodule
`default_nettype wire

### sv/bavg_ctrl.sv
`default_nettype none
module bavg_ctrl
  import bavg_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire logic      out_free,
  input  wire bavg_sts_t sts,
  output bavg_cmd_t      cmd
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_ADD  = 2'd1;
  localparam logic [1:0] ST_DIV  = 2'd2;

  logic [1:0] state_r, state_nxt;

  assign in_ready = (state_r == ST_IDLE);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          if (sts.in_range) begin
            state_nxt = ST_ADD;
          end
        end
      end
      ST_ADD: begin
        cmd.commit = 1'b1;
        if (sts.emit) begin
          cmd.div_start = 1'b1;
          state_nxt     = ST_DIV;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_DIV: begin
        if (sts.div_idle && out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

`ifndef ASSERT_OFF
  a_add_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ADD) |-> ($past(state_r) == ST_IDLE) && $past(in_valid))
    else $error("sum stage entered without an accepted item");
  a_load_done: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> sts.div_idle && (state_r == ST_DIV))
    else $error("output loaded before the division finished");
  a_div_follow: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_start |=> (state_r == ST_DIV) && !sts.div_idle)
    else $error("division launch lost");
`endif

endmodule
`default_nettype wire

### sv/block_average_downscale.sv
// Block-average downscaler: one running column sum per icon column, average per block.
// A pixel that closes a block gives its item after the sum update, the bit-serial
//   restoring division and the output load, which waits for a free output register.
// Pixels are taken one at a time; one inside a tracked icon column is summed, and
//   one that closes a block is divided and loaded, before the next is accepted.
// Reset: synchronous, active low; sides to 1, counters and column sums to zero.
`default_nettype none
module block_average_downscale
  import bavg_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // pixel channel
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [PIX_W-1:0]      in_pixel,
  // icon pixel channel
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [SCNT_W-1:0]          out_icon_row,
  output logic [ICOL_W-1:0]          out_icon_col,
  output logic [AVG_W-1:0]           out_average,
  output logic                       out_frame_last,
  // configuration writes
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  // Configuration, held clamped to the legal range so the datapath never
  // sees a zero or oversized side.
  logic [SSIDE_W-1:0] src_rows_r, src_cols_r;
  logic [BSIDE_W-1:0] blk_rows_r, blk_cols_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_rows_r <= SSIDE_W'(1);
      src_cols_r <= SSIDE_W'(1);
      blk_rows_r <= BSIDE_W'(1);
      blk_cols_r <= BSIDE_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_SOURCE_ROWS: src_rows_r <= clamp_src(cfg_wdata);
        REG_SOURCE_COLS: src_cols_r <= clamp_src(cfg_wdata);
        REG_BLOCK_ROWS:  blk_rows_r <= clamp_blk(cfg_wdata[BSIDE_W-1:0]);
        REG_BLOCK_COLS:  blk_cols_r <= clamp_blk(cfg_wdata[BSIDE_W-1:0]);
      endcase
    end
  end

  // Full block area: clipped edge blocks are still divided by this.
  logic [AREA_W-1:0] br_x, bc_x, area;
  logic [DEN_W-1:0]  den;

  assign br_x = AREA_W'(blk_rows_r);
  assign bc_x = AREA_W'(blk_cols_r);
  assign area = br_x * bc_x;
  // half-up rounding: (2*sum + area) / (2*area)
  assign den  = {area, 1'b0};

  bavg_cmd_t cmd;
  bavg_sts_t sts;

  logic              dp_in_range, dp_emit, div_idle, out_free;
  logic [NUM_W-1:0]  num;
  logic [SCNT_W-1:0] item_row;
  logic [ICOL_W-1:0] item_col;
  logic              item_last;
  logic [AVG_W-1:0]  quot;

  // Output item register
  logic              out_valid_r;
  logic [SCNT_W-1:0] out_row_r;
  logic [ICOL_W-1:0] out_col_r;
  logic [AVG_W-1:0]  out_avg_r;
  logic              out_last_r;

  assign sts.in_range = dp_in_range;
  assign sts.emit     = dp_emit;
  assign sts.div_idle = div_idle;

  // The output register frees the pipeline once the quotient is parked.
  assign out_free = !out_valid_r || out_ready;

  bavg_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .out_free (out_free),
    .sts      (sts),
    .cmd      (cmd)
  );

  bavg_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_pixel  (in_pixel),
    .src_rows  (src_rows_r),
    .src_cols  (src_cols_r),
    .blk_rows  (blk_rows_r),
    .blk_cols  (blk_cols_r),
    .area      (area),
    .in_range  (dp_in_range),
    .emit      (dp_emit),
    .num       (num),
    .item_row  (item_row),
    .item_col  (item_col),
    .item_last (item_last)
  );

  bavg_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (num),
    .den   (den),
    .idle  (div_idle),
    .quot  (quot)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_row_r  <= item_row;
      out_col_r  <= item_col;
      out_avg_r  <= quot;
      out_last_r <= item_last;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_icon_row   = out_row_r;
  assign out_icon_col   = out_col_r;
  assign out_average    = out_avg_r;
  assign out_frame_last = out_last_r;

`ifndef ASSERT_OFF
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> !out_valid_r || out_ready)
    else $error("waiting item overwritten");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |-> div_idle)
    else $error("item accepted during a division");
  a_area_range: assert property (@(posedge clk) disable iff (!rst_n)
    (area != '0) && (area <= AREA_W'(MAX_BLOCK_SIDE * MAX_BLOCK_SIDE)))
    else $error("block area out of range");
`endif

endmodule
`default_nettype wire
